/* rtl/adaptive_range_splitter_macros.svh */
// Assertion macros shared by the range splitter modules.
`ifndef ADAPTIVE_RANGE_SPLITTER_MACROS_SVH
`define ADAPTIVE_RANGE_SPLITTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ars_pkg.sv */
// Package with the constants, codes and control types of the range splitter.
`default_nettype none
package ars_pkg;

  localparam int WIN_DEPTH  = 8;
  localparam int PTR_W      = $clog2(WIN_DEPTH);
  localparam int BLK_LOG2   = 26;
  localparam int BUF_LOG2   = 24;
  localparam int ALIGN_LOG2 = 12;
  localparam int MAX_SUBS   = 16;
  localparam int RESULT_CAP = 16;
  localparam int SUB_CAP    = (MAX_SUBS < RESULT_CAP) ? MAX_SUBS : RESULT_CAP;

  localparam int ADDR_W      = 64;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int SUB_LEN_W   = 25;
  localparam int BLK_IDX_W   = 38;
  localparam int SUB_IDX_W   = 4;
  localparam int OFF_W       = BLK_LOG2 + 1;

  localparam logic [OFF_W-1:0] BLK_SPAN = OFF_W'(1) << BLK_LOG2;
  localparam logic [OFF_W-1:0] BUF_SPAN = OFF_W'(1) << BUF_LOG2;
  localparam logic [CNT_W-1:0] SUB_CAP_V = CNT_W'(SUB_CAP);
  localparam logic [CNT_W-1:0] MAX_SUB_RESET = CNT_W'(8);

  localparam logic CMD_SPLIT  = 1'b0;
  localparam logic CMD_RECORD = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SETTING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ARG     = 2'd2;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit;
  } ars_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_sub;
  } ars_stat_t;

endpackage
`default_nettype wire

/* rtl/adaptive_range_splitter.sv */
// Top level of the adaptive range splitter: controller and datapath.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-----------------------------------------------
//   in        | in_valid/in_stall   | cmd, start_addr, stream_id, progress, count_value
//   out       | out_valid/out_stall | status, sub_start, sub_len, block_index, ...
//   cfg       | cfg_wr_en           | cfg_wr_data (max_sub_count)
//
// An item is captured, then evaluated, then emitted as n results with n from 1 to 4;
// the emit loop of the shared result register sends them and waits while out_stall holds.
// The window maximum is taken in the capture cycle from the eight stored counts.
// Reset is synchronous; in_stall is high during reset and clears on the clock edge after it.
// A stalled result holds in the output register while the next result waits.
`default_nettype none
module adaptive_range_splitter import ars_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_cmd,
  input  logic [ADDR_W-1:0]        in_start_addr,
  input  logic signed [DATA_W-1:0] in_stream_id,
  input  logic signed [DATA_W-1:0] in_progress,
  input  logic [CNT_W-1:0]         in_count_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [ADDR_W-1:0]        out_sub_start,
  output logic [SUB_LEN_W-1:0]     out_sub_len,
  output logic [BLK_IDX_W-1:0]     out_block_index,
  output logic [SUB_IDX_W-1:0]     out_sub_index,
  output logic [CNT_W-1:0]         out_sub_count,
  output logic signed [DATA_W-1:0] out_stream_out,
  output logic signed [DATA_W-1:0] out_progress_out,
  output logic                     out_last
);

  ars_cmd_t  ctl_cmd;
  ars_stat_t ctl_stat;

  ars_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctl_stat (ctl_stat),
    .ctl_cmd  (ctl_cmd)
  );

  ars_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl_cmd          (ctl_cmd),
    .ctl_stat         (ctl_stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_cmd           (in_cmd),
    .in_start_addr    (in_start_addr),
    .in_stream_id     (in_stream_id),
    .in_progress      (in_progress),
    .in_count_value   (in_count_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_sub_start    (out_sub_start),
    .out_sub_len      (out_sub_len),
    .out_block_index  (out_block_index),
    .out_sub_index    (out_sub_index),
    .out_sub_count    (out_sub_count),
    .out_stream_out   (out_stream_out),
    .out_progress_out (out_progress_out),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

/* rtl/ars_ctrl.sv */
// Controller state machine that sequences capture, evaluation and emission.
`default_nettype none
`include "adaptive_range_splitter_macros.svh"
module ars_ctrl import ars_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ars_stat_t ctl_stat,
  output ars_cmd_t  ctl_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    ctl_cmd.capture = in_valid && !in_stall_r;
    ctl_cmd.eval    = (state_r == S_EVAL);
    ctl_cmd.emit    = (state_r == S_EMIT) && ctl_stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl_cmd.capture) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (ctl_cmd.emit && ctl_stat.last_sub) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  `ARS_ASSERT_NXT(a_capture_eval, clk, rst_n, ctl_cmd.capture, state_r == S_EVAL, "capture not followed by evaluation")
  `ARS_ASSERT_NXT(a_eval_emit, clk, rst_n, state_r == S_EVAL, state_r == S_EMIT && in_stall, "evaluation not followed by emission")
  `ARS_ASSERT_NXT(a_last_idle, clk, rst_n, ctl_cmd.emit && ctl_stat.last_sub, state_r == S_IDLE && !in_stall, "final result did not release the input")
  `ARS_ASSERT_IMP(a_capture_idle, clk, rst_n, ctl_cmd.capture, state_r == S_IDLE, "item taken while busy")

endmodule
`default_nettype wire

/* rtl/ars_datapath.sv */
// Datapath with the count window, request registers, split arithmetic and result register.
`default_nettype none
`include "adaptive_range_splitter_macros.svh"
module ars_datapath import ars_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ars_cmd_t                 ctl_cmd,
  output ars_stat_t                ctl_stat,
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data,
  input  logic                     in_cmd,
  input  logic [ADDR_W-1:0]        in_start_addr,
  input  logic signed [DATA_W-1:0] in_stream_id,
  input  logic signed [DATA_W-1:0] in_progress,
  input  logic [CNT_W-1:0]         in_count_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [ADDR_W-1:0]        out_sub_start,
  output logic [SUB_LEN_W-1:0]     out_sub_len,
  output logic [BLK_IDX_W-1:0]     out_block_index,
  output logic [SUB_IDX_W-1:0]     out_sub_index,
  output logic [CNT_W-1:0]         out_sub_count,
  output logic signed [DATA_W-1:0] out_stream_out,
  output logic signed [DATA_W-1:0] out_progress_out,
  output logic                     out_last
);

  logic [CNT_W-1:0]    max_r;
  logic [CNT_W-1:0]    win_r [WIN_DEPTH];
  logic [PTR_W-1:0]    wp_r;
  logic                cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   stream_r;
  logic [DATA_W-1:0]   prog_r;
  logic [CNT_W-1:0]    cv_r;
  logic [CNT_W-1:0]    wmax_r;
  logic [STATUS_W-1:0] stat_r;
  logic                single_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUB_IDX_W-1:0] k_r;
  logic [OFF_W-1:0]    off_r;
  logic                out_valid_r;

  logic [CNT_W-1:0]    wmax_nxt;
  logic [STATUS_W-1:0] stat_nxt;
  logic                single_nxt;
  logic                rec_ok;
  logic [OFF_W-1:0]    off_nxt;
  logic [OFF_W-1:0]    size;
  logic [OFF_W-1:0]    rnd;
  logic [CNT_W-1:0]    cnt_raw;
  logic [CNT_W-1:0]    cnt_win;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [OFF_W-1:0]    rem;
  logic [OFF_W-1:0]    len;

  always_comb begin
    wmax_nxt = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (win_r[i] > wmax_nxt) wmax_nxt = win_r[i];
    end
  end

  always_comb begin
    off_nxt = {1'b0, addr_r[BLK_LOG2-1:ALIGN_LOG2], {ALIGN_LOG2{1'b0}}};
    size    = BLK_SPAN - off_nxt;
    rnd     = size + BUF_SPAN - OFF_W'(1);
    cnt_raw = CNT_W'(rnd[OFF_W-1:BUF_LOG2]);
    cnt_win = (cnt_raw > wmax_r) ? wmax_r : cnt_raw;
    cnt_nxt = (cnt_win > SUB_CAP_V) ? SUB_CAP_V : cnt_win;
  end

  always_comb begin
    rec_ok     = 1'b0;
    single_nxt = 1'b1;
    stat_nxt   = ST_OK;
    if (cmd_r == CMD_RECORD) begin
      if (cv_r > max_r) begin
        stat_nxt = ST_BAD_ARG;
      end else begin
        rec_ok = 1'b1;
      end
    end else if (max_r == '0) begin
      stat_nxt = ST_BAD_SETTING;
    end else if (wmax_r == '0 || wmax_r > max_r) begin
      stat_nxt = ST_BAD_SETTING;
    end else if (addr_r == '1 || stream_r == '1) begin
      stat_nxt = ST_BAD_ARG;
    end else begin
      single_nxt = 1'b0;
    end
  end

  always_comb begin
    rem = BLK_SPAN - off_r;
    len = (rem > BUF_SPAN) ? BUF_SPAN : rem;
  end

  always_comb begin
    ctl_stat.out_free = !out_valid_r || !out_stall;
    ctl_stat.last_sub = single_r || ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_SUB_RESET;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= MAX_SUB_RESET;
      end
    end else begin
      if (cfg_wr_en) max_r <= cfg_wr_data;
      if (ctl_cmd.eval && rec_ok) begin
        win_r[wp_r] <= cv_r;
        wp_r        <= (wp_r == PTR_W'(WIN_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (ctl_cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.capture) begin
      cmd_r    <= in_cmd;
      addr_r   <= in_start_addr;
      stream_r <= in_stream_id;
      prog_r   <= in_progress;
      cv_r     <= in_count_value;
      wmax_r   <= wmax_nxt;
    end
    if (ctl_cmd.eval) begin
      stat_r   <= stat_nxt;
      single_r <= single_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= '0;
      off_r    <= off_nxt;
    end
    if (ctl_cmd.emit) begin
      k_r   <= k_r + SUB_IDX_W'(1);
      off_r <= off_r + len;
      if (single_r) begin
        out_status       <= stat_r;
        out_sub_start    <= '0;
        out_sub_len      <= '0;
        out_block_index  <= '0;
        out_sub_index    <= '0;
        out_sub_count    <= '0;
        out_stream_out   <= '0;
        out_progress_out <= '0;
        out_last         <= 1'b1;
      end else begin
        out_status       <= ST_OK;
        out_sub_start    <= {addr_r[ADDR_W-1:BLK_LOG2], off_r[BLK_LOG2-1:0]};
        out_sub_len      <= len[SUB_LEN_W-1:0];
        out_block_index  <= addr_r[ADDR_W-1:BLK_LOG2];
        out_sub_index    <= k_r;
        out_sub_count    <= cnt_r;
        out_stream_out   <= stream_r;
        out_progress_out <= prog_r;
        out_last         <= ctl_stat.last_sub;
      end
    end
  end

  assign out_valid = out_valid_r;

  `ARS_ASSERT_IMP(a_err_last, clk, rst_n, out_valid_r && out_status != ST_OK, out_last, "error result without last")
  `ARS_ASSERT_IMP(a_idx_bound, clk, rst_n, out_valid_r && !out_last, (CNT_W'(out_sub_index) + CNT_W'(1)) < out_sub_count, "sub index past count")
  `ARS_ASSERT_IMP(a_in_block, clk, rst_n, ctl_cmd.emit && !single_r, off_r[BLK_LOG2] == 1'b0, "sub-request crosses block boundary")

endmodule
`default_nettype wire
